// ----- rtl/pcs_enc_pkg.sv -----
// shared types and constants for the 64b/66b encoder and scrambler
// no dependencies; used by all files under rtl

package pcs_enc_pkg;

  // block geometry
  localparam int BLOCK_W     = 64;
  localparam int BLOCK_BYTES = 8;
  localparam int DIGIT_W     = 8;
  localparam int DIGITS      = BLOCK_W / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(DIGITS);

  // scrambler x^58 + x^39 + 1
  localparam int SCR_W     = 58;
  localparam int SCR_TAP_A = 38;
  localparam int SCR_TAP_B = 57;

  // sync headers
  localparam logic [1:0] SYNC_CTRL = 2'd1;
  localparam logic [1:0] SYNC_DATA = 2'd2;

  // block type bytes
  localparam logic [7:0] IDLE_TYPE        = 8'h1e;
  localparam logic [7:0] START_LANE4_TYPE = 8'h33;
  localparam logic [7:0] START_LANE0_TYPE = 8'h78;

  // inter-frame gap floor
  localparam int MIN_GAP = 12;

  // one block handed to the scrambler
  typedef struct packed {
    logic               valid;
    logic [1:0]         sync;
    logic [BLOCK_W-1:0] payload;
    logic               last;
  } blk_req_t;

  // terminate block type by count of leftover bytes
  function automatic logic [7:0] term_type(input logic [2:0] cnt);
    logic [7:0] t;
    case (cnt)
      3'd0: t = 8'h87;
      3'd1: t = 8'h99;
      3'd2: t = 8'haa;
      3'd3: t = 8'hb4;
      3'd4: t = 8'hcc;
      3'd5: t = 8'hd2;
      3'd6: t = 8'he1;
      3'd7: t = 8'hff;
      default: t = 8'h87;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/pcs_enc_scrambler.sv -----
// digit-serial self-synchronizing scrambler with output register
// depends on pcs_enc_pkg

module pcs_enc_scrambler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pcs_enc_pkg::blk_req_t            req_i,
  output logic                             req_ready_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       sync_hdr_o,
  output logic [pcs_enc_pkg::BLOCK_W-1:0]  block_word_o,
  output logic                             last_of_run_o
);

  localparam int BW = pcs_enc_pkg::BLOCK_W;
  localparam int DW = pcs_enc_pkg::DIGIT_W;
  localparam int SW = pcs_enc_pkg::SCR_W;
  localparam int CW = pcs_enc_pkg::DIGIT_CNT_W;

  logic          run_q, hold_q;
  logic [CW-1:0] cnt_q;
  logic [BW-1:0] pay_q, res_q;
  logic [1:0]    sync_q;
  logic          last_q;
  logic [SW-1:0] scr_q, scr_d;
  logic [DW-1:0] digit, digit_rev;

  logic          ovalid_q, olast_q;
  logic [1:0]    osync_q;
  logic [BW-1:0] oword_q;

  logic req_take, out_load;

  assign req_ready_o = !run_q && !hold_q;
  assign req_take    = req_i.valid && req_ready_o;
  assign out_load    = hold_q && (!ovalid_q || !out_stall_i);

  // one digit of scrambled bits; taps never reach bits made in this digit
  always_comb begin
    for (int k = 0; k < DW; k++) begin
      digit[k] = pay_q[k] ^ scr_q[pcs_enc_pkg::SCR_TAP_A - k]
                          ^ scr_q[pcs_enc_pkg::SCR_TAP_B - k];
      digit_rev[DW-1-k] = digit[k];
    end
    scr_d = {scr_q[SW-DW-1:0], digit_rev};
  end

  // block sequencing: load, shift digits, hold for output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      hold_q <= 1'b0;
      cnt_q  <= '0;
      scr_q  <= '1;
    end else begin
      if (req_take) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        scr_q <= scr_d;
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(pcs_enc_pkg::DIGITS - 1)) begin
          run_q  <= 1'b0;
          hold_q <= 1'b1;
        end
      end else if (out_load) begin
        hold_q <= 1'b0;
      end
    end
  end

  // payload and result shift registers
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      pay_q  <= req_i.payload;
      sync_q <= req_i.sync;
      last_q <= req_i.last;
    end else if (run_q) begin
      pay_q <= {DW'(0), pay_q[BW-1:DW]};
      res_q <= {digit, res_q[BW-1:DW]};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (out_load) begin
      ovalid_q <= 1'b1;
    end else if (!out_stall_i) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      osync_q <= sync_q;
      oword_q <= res_q;
      olast_q <= last_q;
    end
  end

  assign out_valid_o   = ovalid_q;
  assign sync_hdr_o    = osync_q;
  assign block_word_o  = oword_q;
  assign last_of_run_o = olast_q;

endmodule

// ----- rtl/pcs_64b66b_encode_scramble.sv -----
// 64b/66b block encoder: frame bytes in, scrambled 66-bit blocks out
// depends on pcs_enc_pkg and pcs_enc_scrambler
//
//   channel   handshake               payload
//   in        in_valid_i/in_stall_o   frame_byte_i, last_byte_i
//   out       out_valid_o/out_stall_i sync_hdr_o, block_word_o, last_of_run_o
//   cfg       cfg_valid_i/cfg_ready_o idle_gap_i
//
// a byte that completes no block holds the input only while the sequencer
// places it; one that hands blocks to the scrambler holds it until the last is taken.
// the scrambler shifts a block as eight 8-bit digits, holds the result and
// then loads it into the output register, and takes no new block until then.
// reset (async, active low) leaves the block between frames with the
// scrambler all ones and a gap of 12; output stalls back up to in_stall_o.

module pcs_64b66b_encode_scramble #(
  parameter int MAX_GAP = 255
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       frame_byte_i,
  input  logic                             last_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       sync_hdr_o,
  output logic [pcs_enc_pkg::BLOCK_W-1:0]  block_word_o,
  output logic                             last_of_run_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [7:0]                       idle_gap_i
);

  localparam int PendW = $clog2(MAX_GAP + 1);
  localparam int BW    = pcs_enc_pkg::BLOCK_W;

  // sequencer states
  localparam logic [2:0] S_WAIT  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_BYTE  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_TERM  = 3'd4;

  // frame phases
  localparam logic [1:0] PH_GAP   = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  logic [2:0]       state_q;
  logic [1:0]       phase_q;
  logic [PendW-1:0] pending_q;
  logic [7:0]       gap_q;
  logic [BW-1:0]    blk_buf_q, blk_buf_d;
  logic [3:0]       bib_q, bib_inc;
  logic [2:0]       cap_q, pos;
  logic [7:0]       byte_q;
  logic             last_q;

  logic [PendW-1:0] pend_next, eff_gap;
  logic             flush_now;

  pcs_enc_pkg::blk_req_t req;
  logic                  req_ready;

  // clamp a gap value to the legal range
  function automatic logic [PendW-1:0] clamp_gap(input logic [7:0] g);
    logic [PendW-1:0] r;
    if (int'(g) < pcs_enc_pkg::MIN_GAP) begin
      r = PendW'(pcs_enc_pkg::MIN_GAP);
    end else if (int'(g) > MAX_GAP) begin
      r = PendW'(MAX_GAP);
    end else begin
      r = PendW'(g);
    end
    return r;
  endfunction

  assign eff_gap     = clamp_gap(gap_q);
  assign in_stall_o  = (state_q != S_WAIT);
  assign cfg_ready_o = (state_q == S_WAIT) && !in_valid_i;

  // idle count after one more idle block
  assign pend_next = (pending_q >= PendW'(pcs_enc_pkg::BLOCK_BYTES))
                   ? pending_q - PendW'(pcs_enc_pkg::BLOCK_BYTES) : '0;

  // byte placement into the open block
  always_comb begin
    pos       = (phase_q == PH_START) ? bib_q[2:0] - cap_q : bib_q[2:0];
    blk_buf_d = blk_buf_q;
    for (int k = 0; k < pcs_enc_pkg::BLOCK_BYTES; k++) begin
      if (pos == 3'(k)) begin
        blk_buf_d[k*8 +: 8] = blk_buf_q[k*8 +: 8] | byte_q;
      end
    end
    bib_inc   = bib_q + 4'd1;
    flush_now = (phase_q == PH_START) ? ((bib_inc >= {1'b0, cap_q}) || last_q)
                                      : bib_inc[3];
  end

  // block request toward the scrambler
  always_comb begin
    req.valid   = 1'b0;
    req.sync    = pcs_enc_pkg::SYNC_CTRL;
    req.payload = blk_buf_q;
    req.last    = 1'b0;
    case (state_q)
      S_PRE: begin
        req.valid   = (pending_q >= PendW'(5));
        req.payload = BW'(pcs_enc_pkg::IDLE_TYPE);
        req.last    = !last_q && (pend_next < PendW'(5));
      end
      S_FLUSH: begin
        req.valid = 1'b1;
        req.sync  = (phase_q == PH_START) ? pcs_enc_pkg::SYNC_CTRL
                                          : pcs_enc_pkg::SYNC_DATA;
        req.last  = !last_q;
      end
      S_TERM: begin
        req.valid   = 1'b1;
        req.payload = {blk_buf_q[BW-9:0], pcs_enc_pkg::term_type(bib_q[2:0])};
        req.last    = 1'b1;
      end
      default: begin
        req.valid = 1'b0;
      end
    endcase
  end

  // byte sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_WAIT;
      phase_q   <= PH_GAP;
      pending_q <= PendW'(pcs_enc_pkg::MIN_GAP);
      gap_q     <= 8'(pcs_enc_pkg::MIN_GAP);
      blk_buf_q <= '0;
      bib_q     <= '0;
      cap_q     <= 3'd7;
    end else begin
      case (state_q)
        S_WAIT: begin
          if (in_valid_i) begin
            if (phase_q == PH_START || phase_q == PH_DATA) begin
              state_q <= S_BYTE;
            end else begin
              state_q <= S_PRE;
            end
          end else if (cfg_valid_i) begin
            gap_q     <= idle_gap_i;
            pending_q <= clamp_gap(idle_gap_i);
          end
        end
        S_PRE: begin
          if (pending_q >= PendW'(5)) begin
            if (req_ready) begin
              pending_q <= pend_next;
            end
          end else begin
            if (pending_q != '0) begin
              blk_buf_q <= BW'(pcs_enc_pkg::START_LANE4_TYPE);
              cap_q     <= 3'd3;
            end else begin
              blk_buf_q <= BW'(pcs_enc_pkg::START_LANE0_TYPE);
              cap_q     <= 3'd7;
            end
            pending_q <= '0;
            bib_q     <= '0;
            phase_q   <= PH_START;
            state_q   <= S_BYTE;
          end
        end
        S_BYTE: begin
          blk_buf_q <= blk_buf_d;
          bib_q     <= bib_inc;
          if (flush_now) begin
            state_q <= S_FLUSH;
          end else if (last_q) begin
            state_q <= S_TERM;
          end else begin
            state_q <= S_WAIT;
          end
        end
        S_FLUSH: begin
          if (req_ready) begin
            blk_buf_q <= '0;
            bib_q     <= '0;
            phase_q   <= PH_DATA;
            state_q   <= last_q ? S_TERM : S_WAIT;
          end
        end
        S_TERM: begin
          if (req_ready) begin
            pending_q <= eff_gap - PendW'(pcs_enc_pkg::BLOCK_BYTES) + PendW'(bib_q);
            blk_buf_q <= '0;
            bib_q     <= '0;
            phase_q   <= PH_GAP;
            state_q   <= S_WAIT;
          end
        end
        default: begin
          state_q <= S_WAIT;
        end
      endcase
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && in_valid_i) begin
      byte_q <= frame_byte_i;
      last_q <= last_byte_i;
    end
  end

  pcs_enc_scrambler u_scrambler (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .req_ready_o   (req_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .sync_hdr_o    (sync_hdr_o),
    .block_word_o  (block_word_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/pcs_enc_checker.sv -----
// port-level checks for the 64b/66b encoder top level
// depends on pcs_enc_pkg; bound to pcs_64b66b_encode_scramble

module pcs_enc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [1:0]                       sync_hdr_o,
  input logic [pcs_enc_pkg::BLOCK_W-1:0]  block_word_o,
  input logic                             last_of_run_o,
  input logic                             cfg_ready_o
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(block_word_o)
      && $stable(sync_hdr_o) && $stable(last_of_run_o))
    else $error("output word changed while stalled");

  // only control or data sync headers
  a_sync_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sync_hdr_o == pcs_enc_pkg::SYNC_CTRL
      || sync_hdr_o == pcs_enc_pkg::SYNC_DATA))
    else $error("illegal sync header");

  // every accepted byte occupies the sequencer and stalls the input behind it
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("byte accepted on consecutive cycles");

  // register writes only while the byte side is open
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o |-> !in_stall_o)
    else $error("config ready while busy");

endmodule

bind pcs_64b66b_encode_scramble pcs_enc_checker u_pcs_enc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .sync_hdr_o    (sync_hdr_o),
  .block_word_o  (block_word_o),
  .last_of_run_o (last_of_run_o),
  .cfg_ready_o   (cfg_ready_o)
);

// ----- verif/pcs_64b66b_encode_scramble_test.sv -----
// self-checking testbench for the 64b/66b encoder and scrambler
// depends on rtl/pcs_enc_pkg.sv and rtl/pcs_64b66b_encode_scramble.sv
// drives frames with and without random idling and stalls, predicts every block in line

module pcs_64b66b_encode_scramble_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GAP_CEIL      = 255;
  localparam int SETTLE_CYCLES = 24;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int IDLE_PCT      = 15;
  localparam int BW            = pcs_enc_pkg::BLOCK_W;
  localparam int SW            = pcs_enc_pkg::SCR_W;

  typedef enum logic [1:0] {
    PH_GAP   = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2
  } frame_phase_e;

  typedef struct packed {
    logic [1:0]    sync;
    logic [BW-1:0] word;
    logic          last;
  } block_t;

  logic          clk_i        = 1'b0;
  logic          rst_ni       = 1'b0;
  logic          in_valid_i   = 1'b0;
  logic          in_stall_o;
  logic [7:0]    frame_byte_i = 8'h00;
  logic          last_byte_i  = 1'b0;
  logic          out_valid_o;
  logic          out_stall_i  = 1'b0;
  logic [1:0]    sync_hdr_o;
  logic [BW-1:0] block_word_o;
  logic          last_of_run_o;
  logic          cfg_valid_i  = 1'b0;
  logic          cfg_ready_o;
  logic [7:0]    idle_gap_i   = 8'd12;

  // encoder state as the testbench sees it
  logic [7:0]    gap_setting   = 8'd12;
  logic [SW-1:0] scr_state     = '1;
  logic [8:0]    idles_left    = 9'd12;
  logic [BW-1:0] block_acc     = '0;
  logic [3:0]    acc_bytes     = 4'd0;
  frame_phase_e  phase         = PH_GAP;
  logic [2:0]    start_room    = 3'd7;
  int            blocks_of_byte;

  block_t expected_blocks[$];
  bit     idle_on = 1'b1;
  int     n_fail  = 0;

  pcs_64b66b_encode_scramble #(
    .MAX_GAP(GAP_CEIL)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sync_hdr_o   (sync_hdr_o),
    .block_word_o (block_word_o),
    .last_of_run_o(last_of_run_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .idle_gap_i   (idle_gap_i)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  function automatic logic [8:0] clamp_gap(input logic [7:0] g);
    logic [8:0] e;
    e = {1'b0, g};
    if (e < 9'(pcs_enc_pkg::MIN_GAP)) e = 9'(pcs_enc_pkg::MIN_GAP);
    if (e > 9'(GAP_CEIL)) e = 9'(GAP_CEIL);
    return e;
  endfunction

  // scramble one payload and queue the block
  task automatic scramble_block(input logic [1:0] sync, input logic [BW-1:0] payload);
    logic [BW-1:0] w;
    logic          b;
    block_t        blk;
    for (int i = 0; i < BW; i++) begin
      b = payload[i] ^ scr_state[pcs_enc_pkg::SCR_TAP_A] ^ scr_state[pcs_enc_pkg::SCR_TAP_B];
      scr_state = {scr_state[SW-2:0], b};
      w[i] = b;
    end
    blk.sync = sync;
    blk.word = w;
    blk.last = 1'b0;
    expected_blocks.push_back(blk);
    blocks_of_byte++;
  endtask

  // blocks caused by one accepted frame byte
  task automatic encode_byte(input logic [7:0] b, input logic lst);
    logic [2:0] pos;
    logic [2:0] left;
    block_t     blk;
    blocks_of_byte = 0;

    // open a frame: idle blocks, then pick the start block form
    if (phase != PH_START && phase != PH_DATA) begin
      while (idles_left >= 8) begin
        scramble_block(pcs_enc_pkg::SYNC_CTRL, {56'd0, pcs_enc_pkg::IDLE_TYPE});
        idles_left = idles_left - 9'd8;
      end
      if (idles_left >= 1 && idles_left <= 4) begin
        block_acc  = {56'd0, pcs_enc_pkg::START_LANE4_TYPE};
        start_room = 3'd3;
      end else begin
        if (idles_left >= 5) begin
          scramble_block(pcs_enc_pkg::SYNC_CTRL, {56'd0, pcs_enc_pkg::IDLE_TYPE});
        end
        block_acc  = {56'd0, pcs_enc_pkg::START_LANE0_TYPE};
        start_room = 3'd7;
      end
      idles_left = 9'd0;
      acc_bytes  = 4'd0;
      phase      = PH_START;
    end

    if (phase == PH_START) begin
      pos = 3'(4'd8 - {1'b0, start_room} + acc_bytes);
      block_acc = block_acc | ({56'd0, b} << (8 * pos));
      acc_bytes++;
      if (acc_bytes >= {1'b0, start_room} || lst) begin
        scramble_block(pcs_enc_pkg::SYNC_CTRL, block_acc);
        block_acc = '0;
        acc_bytes = 4'd0;
        phase     = PH_DATA;
      end
    end else begin
      block_acc = block_acc | ({56'd0, b} << (8 * acc_bytes[2:0]));
      acc_bytes++;
      if (acc_bytes >= 4'd8) begin
        scramble_block(pcs_enc_pkg::SYNC_DATA, block_acc);
        block_acc = '0;
        acc_bytes = 4'd0;
      end
    end

    // close the frame with a terminate block
    if (lst) begin
      left = acc_bytes[2:0];
      scramble_block(pcs_enc_pkg::SYNC_CTRL,
                     (block_acc << 8) | {56'd0, pcs_enc_pkg::term_type(left)});
      idles_left = clamp_gap(gap_setting) - (9'd8 - {6'd0, left});
      block_acc  = '0;
      acc_bytes  = 4'd0;
      phase      = PH_GAP;
    end

    if (blocks_of_byte > 0) begin
      blk = expected_blocks[expected_blocks.size()-1];
      blk.last = 1'b1;
      expected_blocks[expected_blocks.size()-1] = blk;
    end
  endtask

  // compare every accepted block with the oldest prediction
  always @(posedge clk_i) begin
    block_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected block: sync %0d word %h", sync_hdr_o, block_word_o);
        n_fail++;
      end else begin
        want = expected_blocks.pop_front();
        if (sync_hdr_o !== want.sync) begin
          $error("sync_hdr: expected %0d, actual %0d", want.sync, sync_hdr_o);
          n_fail++;
        end
        if (block_word_o !== want.word) begin
          $error("block_word: expected %h, actual %h", want.word, block_word_o);
          n_fail++;
        end
        if (last_of_run_o !== want.last) begin
          $error("last_of_run: expected %0d, actual %0d", want.last, last_of_run_o);
          n_fail++;
        end
      end
    end
  end

  // one frame byte over the input channel, called at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic lst);
    while (idle_on && ($urandom_range(99) < IDLE_PCT)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    encode_byte(b, lst);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int len);
    for (int k = 0; k < len; k++) send_byte(8'($urandom_range(255)), k == len - 1);
  endtask

  // stop sending and let every predicted block come out
  task automatic wait_quiet();
    int guard;
    guard = 0;
    in_valid_i <= 1'b0;
    while (expected_blocks.size() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk_i);
      guard++;
    end
    if (expected_blocks.size() != 0) begin
      $error("blocks never delivered: %0d", expected_blocks.size());
      n_fail++;
      expected_blocks.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // gap register write, only while the encoder is idle
  task automatic write_gap(input logic [7:0] g);
    cfg_valid_i <= 1'b1;
    idle_gap_i  <= g;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    gap_setting = g;
    idles_left  = clamp_gap(g);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // frames ending in the start block, on a full start block and on a full data block
  task automatic test_frame_shapes();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'ha5, 1'b1);
    for (int k = 0; k < 11; k++) send_byte(k[0] ? 8'hff : 8'h00, k == 10);
    wait_quiet();
  endtask

  // clamped, widest and odd gaps: every start block form
  task automatic test_gap_settings();
    write_gap(8'd0);
    send_byte(8'h5a, 1'b1);
    wait_quiet();
    write_gap(8'd255);
    send_byte(8'hff, 1'b1);
    wait_quiet();
    write_gap(8'd13);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7e, 1'b1);
    wait_quiet();
    write_gap(8'd16);
    send_byte(8'h3c, 1'b1);
    wait_quiet();
  endtask

  // random frames, mostly short, under one gap setting
  task automatic test_random_frames(input logic [7:0] g, input int n_items, input bit quiet);
    int sent;
    int len;
    sent = 0;
    write_gap(g);
    idle_on = !quiet;
    while (sent < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(24, 1);
      if (len > n_items - sent) len = n_items - sent;
      send_frame(len);
      sent += len;
    end
    wait_quiet();
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_frame_shapes();
    test_gap_settings();
    test_random_frames(8'($urandom_range(255)), 23, 1'b0);
    test_random_frames(8'd12, 23, 1'b0);
    test_random_frames(8'd255, 23, 1'b0);
    test_random_frames(8'($urandom_range(255)), 23, 1'b1);

    if (n_fail == 0 && expected_blocks.size() == 0) begin
      $display("pcs_64b66b_encode_scramble test passed");
    end else begin
      $display("pcs_64b66b_encode_scramble test failed");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #3ms;
    $display("pcs_64b66b_encode_scramble test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pcs_enc_pkg.sv
rtl/pcs_enc_scrambler.sv
rtl/pcs_64b66b_encode_scramble.sv
rtl/pcs_enc_checker.sv
verif/pcs_64b66b_encode_scramble_test.sv
